### sv/arcade_key_to_gamepad_mapper_top_macros.svh
// Assertion macros for the arcade key to gamepad mapper.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ARCADE_KEY_TO_GAMEPAD_MAPPER_TOP_MACROS_SVH
`define ARCADE_KEY_TO_GAMEPAD_MAPPER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define AKGM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in %m");
`define AKGM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition in %m");
`else
`define AKGM_ASSERT(lbl, clk, rst_n, prop)
`define AKGM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/akgm_pkg.sv
// Shared types, codes and helper functions for the arcade key to gamepad mapper.
// No dependencies.
`default_nettype none
package akgm_pkg;

    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 32;
    localparam int M_TUSER_W      = 4;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 15;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_SLOTS      = 3;
    localparam int NUM_PLAYERS    = 2;
    localparam int MAX_EVTS       = 8;
    localparam int CNT_W          = 10;
    localparam int MAG_W          = 15;
    localparam int VAL_W          = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIMEOUT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_DEFL    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIAG_DEFL    = 2'd2;

    localparam logic [CNT_W-1:0] HOLD_TIMEOUT_RST = 10'd350;
    localparam logic [MAG_W-1:0] FULL_DEFL_RST    = 15'd32767;
    localparam logic [MAG_W-1:0] DIAG_DEFL_RST    = 15'd23170;
    localparam logic [CNT_W-1:0] CNT_MAX          = 10'd1023;

    localparam logic [1:0] DEV_P1    = 2'd0;
    localparam logic [1:0] DEV_P2    = 2'd1;
    localparam logic [1:0] DEV_COMBO = 2'd2;

    localparam logic [1:0] KIND_KEY = 2'd0;
    localparam logic [1:0] KIND_ABS = 2'd1;
    localparam logic [1:0] KIND_SYN = 2'd2;

    localparam logic [9:0] PAD_SOUTH  = 10'd304;
    localparam logic [9:0] PAD_EAST   = 10'd305;
    localparam logic [9:0] PAD_NORTH  = 10'd307;
    localparam logic [9:0] PAD_SELECT = 10'd314;
    localparam logic [9:0] PAD_START  = 10'd315;
    localparam logic [9:0] KEY_ESC    = 10'd1;
    localparam logic [9:0] AXIS_X     = 10'd0;
    localparam logic [9:0] AXIS_Y     = 10'd1;

    // slot indexes of debounced keys
    localparam logic [1:0] SLOT_P1_START = 2'd0;
    localparam logic [1:0] SLOT_P2_START = 2'd1;
    localparam logic [1:0] SLOT_COIN     = 2'd2;

    // face key indexes
    localparam logic [1:0] FACE_SOUTH = 2'd0;
    localparam logic [1:0] FACE_EAST  = 2'd1;
    localparam logic [1:0] FACE_NORTH = 2'd2;

    // stick direction bit indexes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_STICK    = 2'd1,
        CMD_FACE     = 2'd2,
        CMD_DEBOUNCE = 2'd3
    } cmd_kind_t;

    // unit: player, device or slot; sub: direction or face index
    typedef struct packed {
        cmd_kind_t  kind;
        logic [1:0] unit;
        logic [1:0] sub;
        logic [1:0] val;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       dev;
        logic [1:0]       kind;
        logic [9:0]       code;
        logic [VAL_W-1:0] value;
    } evt_t;

    function automatic evt_t mk_evt(logic [1:0] dev, logic [1:0] kind, logic [9:0] code,
                                    logic [VAL_W-1:0] value);
        evt_t e;
        e.dev   = dev;
        e.kind  = kind;
        e.code  = code;
        e.value = value;
        return e;
    endfunction

    function automatic evt_t mk_sync(logic [1:0] dev);
        return mk_evt(dev, KIND_SYN, 10'd0, '0);
    endfunction

    function automatic logic [1:0] slot_dev(logic [1:0] s);
        return (s == SLOT_P2_START) ? DEV_P2 : DEV_P1;
    endfunction

    function automatic logic [9:0] slot_code(logic [1:0] s);
        return (s == SLOT_COIN) ? PAD_SELECT : PAD_START;
    endfunction

    function automatic logic [9:0] face_code(logic [1:0] f);
        logic [9:0] c;
        unique case (f)
            FACE_EAST:  c = PAD_EAST;
            FACE_NORTH: c = PAD_NORTH;
            default:    c = PAD_SOUTH;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### sv/akgm_front.sv
// Front end: accepts input words, decodes key codes into commands for the queue.
// Depends on akgm_pkg.
`default_nettype none
module akgm_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [akgm_pkg::S_TDATA_W-1:0] s_tdata,   // key_code[7:0], key_value[9:8]
    input  wire logic                           s_tuser,   // opcode
    input  wire logic                           q_full,
    output logic                                q_push,
    output akgm_pkg::cmd_t                      q_data
);
    import akgm_pkg::*;

    localparam logic [7:0] KC_UP1    = 8'd103;
    localparam logic [7:0] KC_DOWN1  = 8'd108;
    localparam logic [7:0] KC_LEFT1  = 8'd105;
    localparam logic [7:0] KC_RIGHT1 = 8'd106;
    localparam logic [7:0] KC_LCTRL  = 8'd29;
    localparam logic [7:0] KC_LALT   = 8'd56;
    localparam logic [7:0] KC_SPACE  = 8'd57;
    localparam logic [7:0] KC_1      = 8'd2;
    localparam logic [7:0] KC_5      = 8'd6;
    localparam logic [7:0] KC_R      = 8'd19;
    localparam logic [7:0] KC_F      = 8'd33;
    localparam logic [7:0] KC_D      = 8'd32;
    localparam logic [7:0] KC_G      = 8'd34;
    localparam logic [7:0] KC_A      = 8'd30;
    localparam logic [7:0] KC_S      = 8'd31;
    localparam logic [7:0] KC_Q      = 8'd16;
    localparam logic [7:0] KC_2      = 8'd3;
    localparam logic [1:0] VAL_IGNORED = 2'd3;

    logic [7:0] key_code;
    logic [1:0] key_value;
    logic       keep;
    cmd_t       cmd;

    assign key_code  = s_tdata[7:0];
    assign key_value = s_tdata[9:8];

    always_comb
    begin
        cmd.kind = CMD_TICK;
        cmd.unit = 2'd0;
        cmd.sub  = 2'd0;
        cmd.val  = key_value;
        keep     = 1'b1;
        if (!s_tuser)
        begin
            unique case (key_code)
                KC_UP1:    begin cmd.kind = CMD_STICK; cmd.unit = 2'd0; cmd.sub = DIR_UP;    end
                KC_DOWN1:  begin cmd.kind = CMD_STICK; cmd.unit = 2'd0; cmd.sub = DIR_DOWN;  end
                KC_LEFT1:  begin cmd.kind = CMD_STICK; cmd.unit = 2'd0; cmd.sub = DIR_LEFT;  end
                KC_RIGHT1: begin cmd.kind = CMD_STICK; cmd.unit = 2'd0; cmd.sub = DIR_RIGHT; end
                KC_LCTRL:  begin cmd.kind = CMD_FACE; cmd.unit = DEV_P1; cmd.sub = FACE_SOUTH; end
                KC_LALT:   begin cmd.kind = CMD_FACE; cmd.unit = DEV_P1; cmd.sub = FACE_EAST;  end
                KC_SPACE:  begin cmd.kind = CMD_FACE; cmd.unit = DEV_P1; cmd.sub = FACE_NORTH; end
                KC_1:      begin cmd.kind = CMD_DEBOUNCE; cmd.unit = SLOT_P1_START; end
                KC_5:      begin cmd.kind = CMD_DEBOUNCE; cmd.unit = SLOT_COIN;     end
                KC_R:      begin cmd.kind = CMD_STICK; cmd.unit = 2'd1; cmd.sub = DIR_UP;    end
                KC_F:      begin cmd.kind = CMD_STICK; cmd.unit = 2'd1; cmd.sub = DIR_DOWN;  end
                KC_D:      begin cmd.kind = CMD_STICK; cmd.unit = 2'd1; cmd.sub = DIR_LEFT;  end
                KC_G:      begin cmd.kind = CMD_STICK; cmd.unit = 2'd1; cmd.sub = DIR_RIGHT; end
                KC_A:      begin cmd.kind = CMD_FACE; cmd.unit = DEV_P2; cmd.sub = FACE_SOUTH; end
                KC_S:      begin cmd.kind = CMD_FACE; cmd.unit = DEV_P2; cmd.sub = FACE_EAST;  end
                KC_Q:      begin cmd.kind = CMD_FACE; cmd.unit = DEV_P2; cmd.sub = FACE_NORTH; end
                KC_2:      begin cmd.kind = CMD_DEBOUNCE; cmd.unit = SLOT_P2_START; end
                default:   keep = 1'b0;
            endcase
            if (key_value == VAL_IGNORED)
            begin
                keep = 1'b0;
            end
        end
    end

    // unmapped and ignored words are taken and dropped here
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;
    assign q_data   = cmd;

endmodule
`default_nettype wire

### sv/akgm_cmd_queue.sv
// Small command FIFO between the decode front end and the event engine.
// Depends on akgm_pkg.
`default_nettype none
module akgm_cmd_queue #(
    parameter int DEPTH = akgm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  akgm_pkg::cmd_t      push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output akgm_pkg::cmd_t      pop_data
);
    import akgm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    cmd_t               mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### sv/akgm_back.sv
// Event engine: carries out queued commands, holds stick and debounce state,
// buffers each run of result words and drains it through the output register.
// Depends on akgm_pkg and the assertion macro header.
`default_nettype none
`include "arcade_key_to_gamepad_mapper_top_macros.svh"
module akgm_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [akgm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [akgm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            q_valid,
    input  akgm_pkg::cmd_t                       q_data,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [akgm_pkg::M_TDATA_W-1:0]       m_tdata,   // event_code[9:0], ev_value[25:10]
    output logic [akgm_pkg::M_TUSER_W-1:0]       m_tuser,   // target_device[1:0], event_kind[3:2]
    output logic                                 m_tlast
);
    import akgm_pkg::*;

    logic [CNT_W-1:0] hold_reg;
    logic [MAG_W-1:0] full_reg;
    logic [MAG_W-1:0] diag_reg;

    logic [3:0]       dir_reg   [NUM_PLAYERS];
    logic [3:0]       dir_next  [NUM_PLAYERS];
    logic [VAL_W-1:0] lastx_reg [NUM_PLAYERS];
    logic [VAL_W-1:0] lastx_next[NUM_PLAYERS];
    logic [VAL_W-1:0] lasty_reg [NUM_PLAYERS];
    logic [VAL_W-1:0] lasty_next[NUM_PLAYERS];
    logic [NUM_SLOTS-1:0] held_reg, held_next;
    logic [NUM_SLOTS-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0] ms_reg  [NUM_SLOTS];
    logic [CNT_W-1:0] ms_next [NUM_SLOTS];
    logic             esc_reg, esc_next;

    evt_t             buf_reg [MAX_EVTS];
    evt_t             list    [MAX_EVTS];
    logic [3:0]       n;
    logic [2:0]       idx_reg, lastidx_reg;
    logic             busy_reg;
    evt_t             out_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    logic             out_free, drain, drain_last;

    // stick scratch
    logic             p;
    logic [3:0]       d, dmask;
    logic             hx_neg, hx_pos, hy_neg, hy_pos;
    logic [VAL_W-1:0] magv, x, y;
    logic             both, pressed;
    logic [1:0]       s2;

    assign out_free   = !out_valid_reg || m_tready;
    assign drain      = busy_reg && out_free;
    assign drain_last = drain && (idx_reg == lastidx_reg);
    assign q_pop      = q_valid && (!busy_reg || drain_last);

    always_comb
    begin
        held_next  = held_reg;
        pend_next  = pend_reg;
        ms_next    = ms_reg;
        esc_next   = esc_reg;
        dir_next   = dir_reg;
        lastx_next = lastx_reg;
        lasty_next = lasty_reg;
        list       = '{default: '0};
        n          = '0;
        p          = q_data.unit[0];
        d          = '0;
        dmask      = 4'b0001 << q_data.sub;
        hx_neg     = 1'b0;
        hx_pos     = 1'b0;
        hy_neg     = 1'b0;
        hy_pos     = 1'b0;
        magv       = '0;
        x          = '0;
        y          = '0;
        both       = 1'b0;
        pressed    = (q_data.val != 2'd0);
        s2         = q_data.unit;
        if (q_pop)
        begin
            unique case (q_data.kind)
                CMD_TICK:
                begin
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (ms_reg[s] != CNT_MAX)
                        begin
                            ms_next[s] = ms_reg[s] + CNT_W'(1);
                        end
                    end
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (held_next[s] && pend_next[s] && (ms_next[s] >= hold_reg))
                        begin
                            list[n[2:0]] = mk_evt(slot_dev(2'(s)), KIND_KEY, slot_code(2'(s)),
                                                  '0);
                            n = n + 4'd1;
                            list[n[2:0]] = mk_sync(slot_dev(2'(s)));
                            n = n + 4'd1;
                            held_next[s] = 1'b0;
                            pend_next[s] = 1'b0;
                            both = held_next[SLOT_P1_START] && held_next[SLOT_P2_START];
                            if (both != esc_next)
                            begin
                                list[n[2:0]] = mk_evt(DEV_COMBO, KIND_KEY, KEY_ESC,
                                                      VAL_W'(both));
                                n = n + 4'd1;
                                list[n[2:0]] = mk_sync(DEV_COMBO);
                                n = n + 4'd1;
                                esc_next = both;
                            end
                        end
                    end
                end
                CMD_STICK:
                begin
                    d = pressed ? (dir_reg[p] | dmask) : (dir_reg[p] & ~dmask);
                    dir_next[p] = d;
                    hx_neg = d[DIR_LEFT] && !d[DIR_RIGHT];
                    hx_pos = d[DIR_RIGHT] && !d[DIR_LEFT];
                    hy_neg = d[DIR_UP] && !d[DIR_DOWN];
                    hy_pos = d[DIR_DOWN] && !d[DIR_UP];
                    magv = ((hx_neg || hx_pos) && (hy_neg || hy_pos)) ? {1'b0, diag_reg}
                                                                     : {1'b0, full_reg};
                    x = hx_neg ? -magv : (hx_pos ? magv : '0);
                    y = hy_neg ? -magv : (hy_pos ? magv : '0);
                    if ((x != lastx_reg[p]) || (y != lasty_reg[p]))
                    begin
                        list[0] = mk_evt({1'b0, p}, KIND_ABS, AXIS_X, x);
                        list[1] = mk_evt({1'b0, p}, KIND_ABS, AXIS_Y, y);
                        list[2] = mk_sync({1'b0, p});
                        n = 4'd3;
                        lastx_next[p] = x;
                        lasty_next[p] = y;
                    end
                end
                CMD_FACE:
                begin
                    list[0] = mk_evt(q_data.unit, KIND_KEY, face_code(q_data.sub),
                                     {14'd0, q_data.val});
                    list[1] = mk_sync(q_data.unit);
                    n = 4'd2;
                end
                CMD_DEBOUNCE:
                begin
                    if (pressed)
                    begin
                        pend_next[s2] = 1'b0;
                        if (!held_reg[s2])
                        begin
                            held_next[s2] = 1'b1;
                            list[0] = mk_evt(slot_dev(s2), KIND_KEY, slot_code(s2), VAL_W'(1));
                            list[1] = mk_sync(slot_dev(s2));
                            n = 4'd2;
                            both = held_next[SLOT_P1_START] && held_next[SLOT_P2_START];
                            if (both != esc_reg)
                            begin
                                list[2] = mk_evt(DEV_COMBO, KIND_KEY, KEY_ESC, VAL_W'(both));
                                list[3] = mk_sync(DEV_COMBO);
                                n = 4'd4;
                                esc_next = both;
                            end
                        end
                    end
                    else
                    begin
                        pend_next[s2] = 1'b1;
                        ms_next[s2]   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= HOLD_TIMEOUT_RST;
            full_reg      <= FULL_DEFL_RST;
            diag_reg      <= DIAG_DEFL_RST;
            dir_reg       <= '{default: '0};
            lastx_reg     <= '{default: '0};
            lasty_reg     <= '{default: '0};
            held_reg      <= '0;
            pend_reg      <= '0;
            ms_reg        <= '{default: '0};
            esc_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            lastidx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_HOLD_TIMEOUT: hold_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_FULL_DEFL:    full_reg <= cfg_wdata[MAG_W-1:0];
                    CFG_DIAG_DEFL:    diag_reg <= cfg_wdata[MAG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            dir_reg   <= dir_next;
            lastx_reg <= lastx_next;
            lasty_reg <= lasty_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            ms_reg    <= ms_next;
            esc_reg   <= esc_next;
            if (drain)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (q_pop)
            begin
                busy_reg    <= (n != 4'd0);
                idx_reg     <= '0;
                lastidx_reg <= n[2:0] - 3'd1;
            end
            else if (drain_last)
            begin
                busy_reg <= 1'b0;
            end
            if (drain)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            buf_reg <= list;
        end
        if (drain)
        begin
            out_reg      <= buf_reg[idx_reg];
            out_last_reg <= (idx_reg == lastidx_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.value, out_reg.code};
    assign m_tuser  = {out_reg.kind, out_reg.dev};
    assign m_tlast  = out_last_reg;

    `AKGM_ASSERT(a_esc_tracks_starts, clk, rst_n, esc_reg == (held_reg[SLOT_P1_START] && held_reg[SLOT_P2_START]))
    `AKGM_ASSERT_NEVER(a_idx_past_run, clk, rst_n, busy_reg && (idx_reg > lastidx_reg))
    `AKGM_ASSERT(a_stall_holds_run, clk, rst_n, (busy_reg && out_valid_reg && !m_tready) |=> (busy_reg && $stable(idx_reg)))

endmodule
`default_nettype wire

### sv/arcade_key_to_gamepad_mapper_top.sv
// Top level of the arcade key to gamepad mapper: decode front end, command queue,
// event engine. Depends on akgm_pkg, akgm_front, akgm_cmd_queue, akgm_back.
//
//  channel   dir  handshake            content
//  s_*       in   tvalid/tready        key event or 1 ms tick, tuser = opcode
//  m_*       out  tvalid/tready/tlast  pad or combo keyboard event words
//  cfg_*     in   cfg_we               hold timeout, full and diagonal deflection
//
// Input words are taken one per cycle while the command queue has room.
// The engine moves one result word per cycle to the output register unless m_tready stalls
// it (up to eight per input) and starts the next command in the cycle it loads the last word.
// Unmapped or ignored words are dropped at the input; others with no result are still queued.
// Reset clears all stick, debounce and escape state; registers return to defaults.
// A stall on m_tready holds the output register and fills the queue behind it.
`default_nettype none
module arcade_key_to_gamepad_mapper_top #(
    parameter int QUEUE_DEPTH = akgm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [akgm_pkg::S_TDATA_W-1:0]  s_tdata,   // key_code[7:0], key_value[9:8]
    input  wire logic                            s_tuser,   // opcode
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [akgm_pkg::M_TDATA_W-1:0]       m_tdata,   // event_code[9:0], ev_value[25:10]
    output logic [akgm_pkg::M_TUSER_W-1:0]       m_tuser,   // target_device[1:0], event_kind[3:2]
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [akgm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [akgm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import akgm_pkg::*;

    logic q_full, q_push, q_valid, q_pop;
    cmd_t push_cmd, pop_cmd;

    akgm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_cmd)
    );

    akgm_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_cmd)
    );

    akgm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_data    (pop_cmd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

### bench/tb_arcade_key_to_gamepad_mapper_top.sv
`timescale 1ns / 100ps
// Testbench for arcade_key_to_gamepad_mapper_top: directed and random key and tick words,
// every output word checked against an in-bench model of sticks, face keys, debounce and escape.
// Depends on akgm_pkg and arcade_key_to_gamepad_mapper_top.
module tb_arcade_key_to_gamepad_mapper_top;
    import akgm_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_MISMATCH_LOG = 10;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KV_RELEASE = 2'd0;
    localparam logic [1:0] KV_PRESS   = 2'd1;
    localparam logic [1:0] KV_REPEAT  = 2'd2;
    localparam logic [1:0] KV_IGNORED = 2'd3;

    localparam logic [7:0] KC_P1_UP    = 8'd103;
    localparam logic [7:0] KC_P1_DOWN  = 8'd108;
    localparam logic [7:0] KC_P1_LEFT  = 8'd105;
    localparam logic [7:0] KC_P1_RIGHT = 8'd106;
    localparam logic [7:0] KC_P1_SOUTH = 8'd29;
    localparam logic [7:0] KC_P1_EAST  = 8'd56;
    localparam logic [7:0] KC_P1_NORTH = 8'd57;
    localparam logic [7:0] KC_P1_START = 8'd2;
    localparam logic [7:0] KC_COIN     = 8'd6;
    localparam logic [7:0] KC_P2_UP    = 8'd19;
    localparam logic [7:0] KC_P2_DOWN  = 8'd33;
    localparam logic [7:0] KC_P2_LEFT  = 8'd32;
    localparam logic [7:0] KC_P2_RIGHT = 8'd34;
    localparam logic [7:0] KC_P2_SOUTH = 8'd30;
    localparam logic [7:0] KC_P2_EAST  = 8'd31;
    localparam logic [7:0] KC_P2_NORTH = 8'd16;
    localparam logic [7:0] KC_P2_START = 8'd3;
    localparam logic [7:0] KC_UNMAPPED = 8'd200;
    localparam logic [7:0] KC_LOWEST   = 8'h00;
    localparam logic [7:0] KC_HIGHEST  = 8'hFF;

    typedef struct packed {
        logic       op;
        logic [7:0] code;
        logic [1:0] val;
        logic [3:0] gap;
    } key_word_t;

    typedef struct packed {
        logic [1:0]       dev;
        logic [1:0]       kind;
        logic [9:0]       code;
        logic [VAL_W-1:0] value;
        logic             last;
    } pad_event_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // model of the mapper
    logic [CNT_W-1:0] hold_timeout;
    logic [MAG_W-1:0] full_mag;
    logic [MAG_W-1:0] diag_mag;
    logic [3:0]       stick_dirs [NUM_PLAYERS];
    logic [VAL_W-1:0] axis_x [NUM_PLAYERS];
    logic [VAL_W-1:0] axis_y [NUM_PLAYERS];
    logic             held [NUM_SLOTS];
    logic             release_armed [NUM_SLOTS];
    logic [CNT_W-1:0] ms_since_up [NUM_SLOTS];
    logic             esc_held;
    int               run_len;

    pad_event_t expected_events [$];
    key_word_t  pending_words [$];

    key_word_t next_word;
    key_word_t word_on_bus;
    logic      word_staged = 1'b0;
    int        gap_left    = 0;
    int        stall_left  = 0;
    int        words_taken = 0;
    int        tx_gap_cap  = 10;
    int        rx_gap_cap  = 10;
    logic      hold_off    = 1'b0;
    int        fault_count = 0;
    int        cycle_count = 0;

    arcade_key_to_gamepad_mapper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void model_reset();
        hold_timeout = HOLD_TIMEOUT_RST;
        full_mag     = FULL_DEFL_RST;
        diag_mag     = DIAG_DEFL_RST;
        for (int p = 0; p < NUM_PLAYERS; p++)
        begin
            stick_dirs[p] = '0;
            axis_x[p]     = '0;
            axis_y[p]     = '0;
        end
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            held[s]          = 1'b0;
            release_armed[s] = 1'b0;
            ms_since_up[s]   = '0;
        end
        esc_held = 1'b0;
    endfunction

    function automatic void emit(logic [1:0] dev, logic [1:0] kind, logic [9:0] code,
                                 logic [VAL_W-1:0] value);
        pad_event_t e;
        if (run_len < MAX_EVTS)
        begin
            e.dev   = dev;
            e.kind  = kind;
            e.code  = code;
            e.value = value;
            e.last  = 1'b0;
            expected_events.push_back(e);
            run_len++;
        end
    endfunction

    function automatic void update_escape();
        logic both;
        both = held[SLOT_P1_START] && held[SLOT_P2_START];
        if (both != esc_held)
        begin
            emit(DEV_COMBO, KIND_KEY, KEY_ESC, both ? 16'd1 : 16'd0);
            emit(DEV_COMBO, KIND_SYN, 10'd0, '0);
            esc_held = both;
        end
    endfunction

    function automatic void emit_slot(logic [1:0] slot, logic [VAL_W-1:0] value);
        logic [1:0] dev;
        logic [9:0] btn;
        dev = (slot == SLOT_P2_START) ? DEV_P2 : DEV_P1;
        btn = (slot == SLOT_COIN) ? PAD_SELECT : PAD_START;
        emit(dev, KIND_KEY, btn, value);
        emit(dev, KIND_SYN, 10'd0, '0);
    endfunction

    function automatic void debounce_key(logic [1:0] slot, logic pressed);
        if (pressed)
        begin
            release_armed[slot] = 1'b0;
            if (!held[slot])
            begin
                held[slot] = 1'b1;
                emit_slot(slot, 16'd1);
                update_escape();
            end
        end
        else
        begin
            release_armed[slot] = 1'b1;
            ms_since_up[slot]   = '0;
        end
    endfunction

    function automatic void move_stick(logic [1:0] dev, logic [1:0] dir, logic pressed);
        logic             pl;
        logic [3:0]       d;
        int               hx;
        int               hy;
        int               mag;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        pl = dev[0];
        stick_dirs[pl][dir] = pressed;
        d  = stick_dirs[pl];
        hx = 0;
        hy = 0;
        if (d[DIR_LEFT] && !d[DIR_RIGHT])
            hx = -1;
        else if (d[DIR_RIGHT] && !d[DIR_LEFT])
            hx = 1;
        if (d[DIR_UP] && !d[DIR_DOWN])
            hy = -1;
        else if (d[DIR_DOWN] && !d[DIR_UP])
            hy = 1;
        mag = (hx != 0 && hy != 0) ? int'(diag_mag) : int'(full_mag);
        x = VAL_W'(hx * mag);
        y = VAL_W'(hy * mag);
        if (x == axis_x[pl] && y == axis_y[pl])
            return;
        emit(dev, KIND_ABS, AXIS_X, x);
        emit(dev, KIND_ABS, AXIS_Y, y);
        emit(dev, KIND_SYN, 10'd0, '0);
        axis_x[pl] = x;
        axis_y[pl] = y;
    endfunction

    function automatic void face_event(logic [1:0] dev, logic [9:0] btn, logic [1:0] val);
        emit(dev, KIND_KEY, btn, VAL_W'(val));
        emit(dev, KIND_SYN, 10'd0, '0);
    endfunction

    function automatic void apply_key(logic [7:0] code, logic [1:0] val);
        logic pressed;
        pressed = (val != KV_RELEASE);
        case (code)
            KC_P1_UP:    move_stick(DEV_P1, DIR_UP, pressed);
            KC_P1_DOWN:  move_stick(DEV_P1, DIR_DOWN, pressed);
            KC_P1_LEFT:  move_stick(DEV_P1, DIR_LEFT, pressed);
            KC_P1_RIGHT: move_stick(DEV_P1, DIR_RIGHT, pressed);
            KC_P1_SOUTH: face_event(DEV_P1, PAD_SOUTH, val);
            KC_P1_EAST:  face_event(DEV_P1, PAD_EAST, val);
            KC_P1_NORTH: face_event(DEV_P1, PAD_NORTH, val);
            KC_P1_START: debounce_key(SLOT_P1_START, pressed);
            KC_COIN:     debounce_key(SLOT_COIN, pressed);
            KC_P2_UP:    move_stick(DEV_P2, DIR_UP, pressed);
            KC_P2_DOWN:  move_stick(DEV_P2, DIR_DOWN, pressed);
            KC_P2_LEFT:  move_stick(DEV_P2, DIR_LEFT, pressed);
            KC_P2_RIGHT: move_stick(DEV_P2, DIR_RIGHT, pressed);
            KC_P2_SOUTH: face_event(DEV_P2, PAD_SOUTH, val);
            KC_P2_EAST:  face_event(DEV_P2, PAD_EAST, val);
            KC_P2_NORTH: face_event(DEV_P2, PAD_NORTH, val);
            KC_P2_START: debounce_key(SLOT_P2_START, pressed);
            default: ;
        endcase
    endfunction

    function automatic void advance_ms();
        for (int s = 0; s < NUM_SLOTS; s++)
            if (ms_since_up[s] != CNT_MAX)
                ms_since_up[s]++;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (held[s] && release_armed[s] && ms_since_up[s] >= hold_timeout)
            begin
                emit_slot(2'(s), 16'd0);
                held[s]          = 1'b0;
                release_armed[s] = 1'b0;
                update_escape();
            end
        end
    endfunction

    function automatic void predict_events(key_word_t w);
        pad_event_t e;
        run_len = 0;
        if (w.op == OP_TICK)
            advance_ms();
        else if (w.val != KV_IGNORED)
            apply_key(w.code, w.val);
        if (run_len > 0)
        begin
            e      = expected_events.pop_back();
            e.last = 1'b1;
            expected_events.push_back(e);
        end
    endfunction

    function automatic void push_word(logic op, logic [7:0] code, logic [1:0] val);
        key_word_t w;
        w.op   = op;
        w.code = code;
        w.val  = val;
        w.gap  = 4'($urandom_range(0, tx_gap_cap));
        pending_words.push_back(w);
    endfunction

    function automatic void push_key(logic [7:0] code, logic [1:0] val);
        push_word(OP_KEY, code, val);
    endfunction

    function automatic logic [7:0] mapped_key(int i);
        logic [7:0] k;
        case (i)
            0:  k = KC_P1_START;
            1:  k = KC_P2_START;
            2:  k = KC_COIN;
            3:  k = KC_P1_UP;
            4:  k = KC_P1_DOWN;
            5:  k = KC_P1_LEFT;
            6:  k = KC_P1_RIGHT;
            7:  k = KC_P1_SOUTH;
            8:  k = KC_P1_EAST;
            9:  k = KC_P1_NORTH;
            10: k = KC_P2_UP;
            11: k = KC_P2_DOWN;
            12: k = KC_P2_LEFT;
            13: k = KC_P2_RIGHT;
            14: k = KC_P2_SOUTH;
            15: k = KC_P2_EAST;
            default: k = KC_P2_NORTH;
        endcase
        return k;
    endfunction

    // mostly press/release traffic on mapped keys and ticks, some noise
    function automatic void push_random(int n);
        int         r;
        int         rv;
        logic [1:0] val;
        for (int i = 0; i < n; i++)
        begin
            r  = $urandom_range(0, 99);
            rv = $urandom_range(0, 99);
            val = (rv < 45) ? KV_PRESS : (rv < 90) ? KV_RELEASE : KV_REPEAT;
            if (r < 35)
                push_word(OP_TICK, 8'($urandom), 2'($urandom));
            else if (r < 50)
                push_key(mapped_key($urandom_range(0, 2)), val);
            else if (r < 88)
                push_key(mapped_key($urandom_range(0, 16)), val);
            else
                push_key(8'($urandom), 2'($urandom));
        end
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(value);
        case (addr)
            CFG_HOLD_TIMEOUT: hold_timeout = CNT_W'(value);
            CFG_FULL_DEFL:    full_mag     = MAG_W'(value);
            CFG_DIAG_DEFL:    diag_mag     = MAG_W'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || word_staged || s_tvalid ||
               expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= 1'b0;
            word_staged = 1'b0;
            gap_left    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_events(word_on_bus);
                words_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (!word_staged && pending_words.size() != 0)
                begin
                    next_word   = pending_words.pop_front();
                    word_staged = 1'b1;
                    gap_left    = next_word.gap;
                end
                if (word_staged && gap_left == 0)
                begin
                    s_tvalid    <= 1'b1;
                    s_tdata     <= {{(S_TDATA_W - 10){1'b0}}, next_word.val, next_word.code};
                    s_tuser     <= next_word.op;
                    word_on_bus = next_word;
                    word_staged = 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (word_staged)
                        gap_left--;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        pad_event_t got;
        pad_event_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.dev   = m_tuser[1:0];
                got.kind  = m_tuser[3:2];
                got.code  = m_tdata[9:0];
                got.value = m_tdata[25:10];
                got.last  = m_tlast;
                if (expected_events.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_MISMATCH_LOG)
                        $display("%0t unexpected word: dev %0d kind %0d code %0d value %0d last %0d",
                                 $realtime, got.dev, got.kind, got.code, $signed(got.value),
                                 got.last);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got.dev !== want.dev || got.kind !== want.kind ||
                        got.code !== want.code || got.value !== want.value ||
                        got.last !== want.last)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_MISMATCH_LOG)
                        begin
                            $display("%0t mismatch: want dev %0d kind %0d code %0d value %0d last %0d",
                                     $realtime, want.dev, want.kind, want.code,
                                     $signed(want.value), want.last);
                            $display("    got dev %0d kind %0d code %0d value %0d last %0d",
                                     got.dev, got.kind, got.code, $signed(got.value), got.last);
                        end
                    end
                end
                stall_left = $urandom_range(0, rx_gap_cap);
            end
            else if (stall_left > 0)
                stall_left--;
            m_tready <= !hold_off && stall_left == 0;
        end
    end

    // long receiver hold-off so the input side backs up
    initial
    begin
        wait (words_taken >= HOLD_OFF_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_arcade_key_to_gamepad_mapper_top: errors");
            $finish;
        end
    end

    initial
    begin
        model_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: 350 ms timeout, diagonal 23170
        tx_gap_cap = 10;
        rx_gap_cap = 10;
        push_key(KC_P1_UP, KV_IGNORED);
        push_key(KC_UNMAPPED, KV_PRESS);
        push_key(KC_HIGHEST, KV_PRESS);
        push_key(KC_LOWEST, KV_RELEASE);
        push_word(OP_TICK, KC_HIGHEST, KV_IGNORED);
        push_key(KC_P1_UP, KV_PRESS);
        push_key(KC_P1_RIGHT, KV_PRESS);
        push_key(KC_P1_LEFT, KV_PRESS);
        push_key(KC_P1_UP, KV_REPEAT);
        push_key(KC_P1_DOWN, KV_PRESS);
        push_key(KC_P1_UP, KV_RELEASE);
        push_key(KC_P1_LEFT, KV_RELEASE);
        push_key(KC_P1_DOWN, KV_RELEASE);
        push_key(KC_P1_RIGHT, KV_RELEASE);
        push_key(KC_P2_LEFT, KV_PRESS);
        push_key(KC_P2_DOWN, KV_PRESS);
        push_key(KC_P2_SOUTH, KV_REPEAT);
        push_key(KC_P1_SOUTH, KV_PRESS);
        push_key(KC_P1_EAST, KV_PRESS);
        push_key(KC_P2_NORTH, KV_RELEASE);
        push_key(KC_COIN, KV_RELEASE);
        push_key(KC_COIN, KV_PRESS);
        push_key(KC_P1_START, KV_PRESS);
        push_key(KC_P2_START, KV_PRESS);
        push_key(KC_P1_START, KV_REPEAT);
        push_key(KC_P1_START, KV_RELEASE);
        push_word(OP_TICK, KC_LOWEST, KV_RELEASE);
        wait_drained();

        // long timeout, full-scale diagonal, back to back
        write_reg(CFG_HOLD_TIMEOUT, 60);
        write_reg(CFG_DIAG_DEFL, 32767);
        tx_gap_cap = 0;
        rx_gap_cap = 0;
        push_key(KC_P1_START, KV_PRESS);
        push_key(KC_P1_START, KV_RELEASE);
        for (int i = 0; i < 62; i++)
            push_word(OP_TICK, 8'($urandom), 2'($urandom));
        push_key(KC_P2_UP, KV_PRESS);
        push_key(KC_P2_RIGHT, KV_PRESS);
        wait_drained();

        // zero timeout, zero diagonal
        write_reg(CFG_HOLD_TIMEOUT, 0);
        write_reg(CFG_FULL_DEFL, 32767);
        write_reg(CFG_DIAG_DEFL, 0);
        tx_gap_cap = 10;
        rx_gap_cap = 10;
        push_random(140);
        wait_drained();

        // zero full deflection, no idling
        write_reg(CFG_HOLD_TIMEOUT, $urandom_range(1, 12));
        write_reg(CFG_FULL_DEFL, 0);
        write_reg(CFG_DIAG_DEFL, 32767);
        tx_gap_cap = 0;
        rx_gap_cap = 0;
        push_random(130);
        wait_drained();

        write_reg(CFG_HOLD_TIMEOUT, $urandom_range(0, 20));
        write_reg(CFG_FULL_DEFL, $urandom_range(0, 32767));
        write_reg(CFG_DIAG_DEFL, $urandom_range(0, 32767));
        tx_gap_cap = 10;
        rx_gap_cap = 10;
        push_random(140);
        wait_drained();

        if (expected_events.size() != 0)
        begin
            fault_count++;
            $display("%0d expected words never arrived", expected_events.size());
        end
        if (fault_count == 0)
            $display("tb_arcade_key_to_gamepad_mapper_top: clean");
        else
            $display("tb_arcade_key_to_gamepad_mapper_top: errors");
        $finish;
    end

endmodule
